// ----- rtl/core/binary_image_rotation_top_macros.svh -----
// assertion macros shared by the rotation block
// no dependencies; included by the top level
`ifndef BINARY_IMAGE_ROTATION_TOP_MACROS_SVH
`define BINARY_IMAGE_ROTATION_TOP_MACROS_SVH

// checked on every clock edge outside reset
`define BIR_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define BIR_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/bir_pkg.sv -----
// types and constants of the binary image rotation block
// no dependencies; used by the interface users and the top level
package bir_pkg;

  localparam int COORD_W  = 9;
  localparam int PIXEL_W  = 8;
  localparam int TRIG_W   = 16;
  localparam int SRC_W    = 9;
  localparam int OUT_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [PIXEL_W-1:0] LIGHT = 8'hFF;
  localparam logic [PIXEL_W-1:0] DARK  = 8'h00;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] SIN_RESET = 16'sd0;
  localparam logic [SRC_W-1:0] SRC_SIZE_RESET = 9'd256;
  localparam logic [OUT_W-1:0] OUT_SIZE_RESET = 10'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS        = 3'd0,
    CFG_SIN        = 3'd1,
    CFG_SRC_WIDTH  = 3'd2,
    CFG_SRC_HEIGHT = 3'd3,
    CFG_OUT_WIDTH  = 3'd4,
    CFG_OUT_HEIGHT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIXEL_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic               inside_res;
  } out_item_t;

endpackage

// ----- rtl/core/bir_stream_if.sv -----
// valid/ready stream channel carrying one payload item
// payload type is set per instance; used with bir_pkg item types
interface bir_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/binary_image_rotation_top.sv -----
// Binary image rotation: 1-bit frame store and inverse-mapping rotate pipeline.
// in_ch carries write items (cmd 0) that store a source pixel and read items
// (cmd 1) that name an output coordinate; out_ch returns one item per read,
// pixel_out 0 for a dark source pixel, 255 for a light one or outside.
// cfg_we/cfg_index/cfg_data write cos, sin and the frame sizes; the user must do
// so only while idle, which the block itself does not enforce. Throughput: one
// item per cycle while out_ch does not stall; five register stages (centering,
// the four 10x16 multiplies, the two sums, truncation plus source offset, bounds
// check with the frame store read) then the output register.
// The frame store is a single-port bit memory of MAX_WIDTH x MAX_HEIGHT;
// writes and reads use it in the same stage, so item order is kept.
// Reset clears the pipeline valid bits and loads the configuration reset
// values; the frame store is not cleared and needs no clearing pass.
// When out_ch stalls, stages fill up behind the output register (bubbles
// collapse) and in_ch.ready drops only once every stage holds an item.
`include "binary_image_rotation_top_macros.svh"

module binary_image_rotation_top
  import bir_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bir_stream_if.sink            in_ch,
  bir_stream_if.source          out_ch
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = CW + RW;
  localparam int DEPTH = 1 << AW;
  localparam int DW = COORD_W + 1;           // centered coordinate
  localparam int PW = DW + TRIG_W;           // one product
  localparam int SW = PW + 1;                // sum of two products
  localparam int NW = SW + 1;                // mapped source coordinate
  localparam logic signed [SW-1:0] BIAS = SW'((64'sd1 <<< FRAC_BITS) - 64'sd1);
  localparam logic [NW-2:0] MAXW = (NW-1)'(MAX_WIDTH);
  localparam logic [NW-2:0] MAXH = (NW-1)'(MAX_HEIGHT);

  // configuration
  logic signed [TRIG_W-1:0] cos_value, sin_value;
  logic [SRC_W-1:0] src_width, src_height;
  logic [OUT_W-1:0] out_width, out_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_value  <= COS_RESET;
      sin_value  <= SIN_RESET;
      src_width  <= SRC_SIZE_RESET;
      src_height <= SRC_SIZE_RESET;
      out_width  <= OUT_SIZE_RESET;
      out_height <= OUT_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_COS:        cos_value  <= cfg_data;
        CFG_SIN:        sin_value  <= cfg_data;
        CFG_SRC_WIDTH:  src_width  <= cfg_data[SRC_W-1:0];
        CFG_SRC_HEIGHT: src_height <= cfg_data[SRC_W-1:0];
        CFG_OUT_WIDTH:  out_width  <= cfg_data[OUT_W-1:0];
        CFG_OUT_HEIGHT: out_height <= cfg_data[OUT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and enables; a stage loads when empty or moving on
  logic v1, v2, v3, v4, v5, out_valid;
  logic en1, en2, en3, en4, en5, en_out;
  logic rd5;
  logic in_fire;

  assign en_out = !out_valid || out_ch.ready;
  assign en5    = !v5 || en_out;
  assign en4    = !v4 || en5;
  assign en3    = !v3 || en4;
  assign en2    = !v2 || en3;
  assign en1    = !v1 || en2;
  assign in_ch.ready = en1;
  assign in_fire = in_ch.valid && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_fire;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      // write items leave the pipe here without a result
      if (en_out) out_valid <= v5 && rd5;
    end
  end

  // stage 1: center the coordinate, prepare the write address
  logic [31:0] wcol_ext, wrow_ext;
  logic signed [DW-1:0] dx1, dy1;
  logic rd1, rd2, rd3;
  logic wok1, wok2, wok3;
  logic wbit1, wbit2, wbit3;
  logic [AW-1:0] waddr1, waddr2, waddr3;

  assign wcol_ext = 32'(in_ch.data.col);
  assign wrow_ext = 32'(in_ch.data.row);

  always_ff @(posedge clk) begin
    if (en1) begin
      rd1    <= (in_ch.data.cmd == CMD_READ);
      dx1    <= $signed({1'b0, in_ch.data.col}) - $signed({1'b0, out_width[OUT_W-1:1]});
      dy1    <= $signed({1'b0, in_ch.data.row}) - $signed({1'b0, out_height[OUT_W-1:1]});
      wok1   <= (wcol_ext < 32'(MAX_WIDTH)) && (wrow_ext < 32'(MAX_HEIGHT));
      wbit1  <= (in_ch.data.pixel_in != '0);
      waddr1 <= {wrow_ext[RW-1:0], wcol_ext[CW-1:0]};
    end
  end

  // stage 2: the four products
  logic signed [PW-1:0] p_xc, p_ys, p_yc, p_xs;

  always_ff @(posedge clk) begin
    if (en2) begin
      rd2    <= rd1;
      wok2   <= wok1;
      wbit2  <= wbit1;
      waddr2 <= waddr1;
      p_xc   <= dx1 * cos_value;
      p_ys   <= dy1 * sin_value;
      p_yc   <= dy1 * cos_value;
      p_xs   <= dx1 * sin_value;
    end
  end

  // stage 3: rotated offsets
  logic signed [SW-1:0] sx3, sy3;

  always_ff @(posedge clk) begin
    if (en3) begin
      rd3    <= rd2;
      wok3   <= wok2;
      wbit3  <= wbit2;
      waddr3 <= waddr2;
      sx3    <= SW'(p_xc) + SW'(p_ys);
      sy3    <= SW'(p_yc) - SW'(p_xs);
    end
  end

  // stage 4: truncate toward zero and add the source half size
  logic signed [SW-1:0] sx_adj, sy_adj, tx, ty;
  logic signed [NW-1:0] nx4, ny4;
  logic rd4a, wok4, wbit4;
  logic [AW-1:0] waddr4;

  always_comb begin
    sx_adj = sx3 + (sx3[SW-1] ? BIAS : '0);
    sy_adj = sy3 + (sy3[SW-1] ? BIAS : '0);
    tx = sx_adj >>> FRAC_BITS;
    ty = sy_adj >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      rd4a   <= rd3;
      wok4   <= wok3;
      wbit4  <= wbit3;
      waddr4 <= waddr3;
      nx4    <= NW'(tx) + NW'($signed({1'b0, src_width[SRC_W-1:1]}));
      ny4    <= NW'(ty) + NW'($signed({1'b0, src_height[SRC_W-1:1]}));
    end
  end

  // stage 5: bounds check and frame store access, shared by writes and reads
  logic inside5, stored5;
  logic in_x, in_y;
  logic [AW-1:0] mem_addr;
  logic mem [DEPTH];

  assign in_x = !nx4[NW-1] && (nx4[NW-2:0] < (NW-1)'(src_width)) && (nx4[NW-2:0] < MAXW);
  assign in_y = !ny4[NW-1] && (ny4[NW-2:0] < (NW-1)'(src_height)) && (ny4[NW-2:0] < MAXH);
  assign mem_addr = rd4a ? {ny4[RW-1:0], nx4[CW-1:0]} : waddr4;

  always_ff @(posedge clk) begin
    if (en5) begin
      if (v4 && !rd4a && wok4) begin
        mem[mem_addr] <= wbit4;
      end
      stored5 <= mem[mem_addr];
      rd5     <= rd4a;
      inside5 <= in_x && in_y;
    end
  end

  // output register
  out_item_t out_data;

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_data.pixel_out  <= (inside5 && !stored5) ? DARK : LIGHT;
      out_data.inside_res <= inside5;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  `BIR_CHECK(a_pixel_code, out_valid |-> (out_data.pixel_out == DARK || out_data.pixel_out == LIGHT), "pixel_out is neither dark nor light")
  `BIR_CHECK(a_outside_light, (out_valid && !out_data.inside_res) |-> (out_data.pixel_out == LIGHT), "point outside the frame is not light")
  `BIR_CHECK(a_full_when_blocked, !in_ch.ready |-> (v1 && v2 && v3 && v4 && v5 && out_valid && !out_ch.ready), "input blocked while a stage is free")
  `BIR_CHECK_ALWAYS(a_reset_empties, $past(rst) |-> (!out_valid && !v1 && !v5), "pipeline not empty after reset")

endmodule

// ----- sim/binary_image_rotation_top_tb.sv -----
// testbench for binary_image_rotation_top: directed rows, then random phases with idling
// uses bir_pkg and bir_stream_if from the rtl; the predictor keeps its own frame copy
`timescale 1ns / 100ps

module binary_image_rotation_top_tb;
  import bir_pkg::*;

  localparam int MAX_W         = 256;
  localparam int MAX_H         = 256;
  localparam int FRAC          = 14;
  localparam int LATENCY       = 5;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 116;
  localparam int IDLE_PCT      = 23;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    cfg_reg_t  idx;
    int        val;
    in_item_t  it;
    bit        typed;
    out_item_t due;
  } plan_row_t;

  typedef struct {
    bit        typed;
    out_item_t due;
  } read_tag_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bir_stream_if #(.payload_t(in_item_t))  in_ch ();
  bir_stream_if #(.payload_t(out_item_t)) out_ch ();

  binary_image_rotation_top #(
    .MAX_WIDTH(MAX_W),
    .MAX_HEIGHT(MAX_H),
    .FRAC_BITS(FRAC)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  // predictor copy of the registers and the frame
  logic signed [TRIG_W-1:0] cos_q;
  logic signed [TRIG_W-1:0] sin_q;
  logic [SRC_W-1:0] src_w_q;
  logic [SRC_W-1:0] src_h_q;
  logic [OUT_W-1:0] out_w_q;
  logic [OUT_W-1:0] out_h_q;
  bit frame_bits [0:MAX_W*MAX_H-1];
  // pixels already sent as writes, so no read ever lands on an unwritten one
  bit frame_sent [0:MAX_W*MAX_H-1];

  out_item_t pixel_due_q [$];
  read_tag_t read_tag_q [$];

  int err_count = 0;
  int n_items = 0;
  int n_reads = 0;
  int n_results = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;
  bit no_idle = 1'b0;

  task automatic report_fail(string msg);
    err_count++;
    if (err_count <= 40) $display("mismatch: %s", msg);
  endtask

  // inverse map of an output coordinate into the source frame
  function automatic bit map_point(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r,
                                   output int addr);
    longint dx, dy, sx, sy, one;
    bit ins;
    one = longint'(1) << FRAC;
    dx = longint'(c) - longint'(out_w_q >> 1);
    dy = longint'(r) - longint'(out_h_q >> 1);
    // integer divide truncates toward zero
    sx = (dx * longint'(cos_q) + dy * longint'(sin_q)) / one + longint'(src_w_q >> 1);
    sy = (dy * longint'(cos_q) - dx * longint'(sin_q)) / one + longint'(src_h_q >> 1);
    ins = sx >= 0 && sy >= 0 && sx < longint'(src_w_q) && sy < longint'(src_h_q) &&
          sx < MAX_W && sy < MAX_H;
    addr = ins ? int'(sy) * MAX_W + int'(sx) : 0;
    return ins;
  endfunction

  function automatic out_item_t rotate_pixel(input in_item_t it);
    out_item_t res;
    int addr;
    bit ins;
    ins = map_point(it.col, it.row, addr);
    res.inside_res = ins;
    res.pixel_out = (ins && !frame_bits[addr]) ? DARK : LIGHT;
    return res;
  endfunction

  // accept and result monitor, sampled at the rising edge
  always @(posedge clk) begin : monitor
    out_item_t due;
    read_tag_t tag;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        n_items++;
        if (in_ch.data.cmd == CMD_WRITE) begin
          if (in_ch.data.col < MAX_W && in_ch.data.row < MAX_H)
            frame_bits[int'(in_ch.data.row) * MAX_W + int'(in_ch.data.col)] =
              (in_ch.data.pixel_in != DARK);
        end else begin
          n_reads++;
          due = rotate_pixel(in_ch.data);
          if (read_tag_q.size() != 0) begin
            tag = read_tag_q.pop_front();
            if (tag.typed) due = tag.due;
          end
          pixel_due_q.push_back(due);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (pixel_due_q.size() == 0) begin
          report_fail($sformatf("result %0d with nothing expected (pixel %0d inside %0b)",
                                n_results, out_ch.data.pixel_out, out_ch.data.inside_res));
        end else begin
          due = pixel_due_q.pop_front();
          if (out_ch.data.pixel_out !== due.pixel_out)
            report_fail($sformatf("result %0d pixel_out %0d, expected %0d",
                                  n_results, out_ch.data.pixel_out, due.pixel_out));
          if (out_ch.data.inside_res !== due.inside_res)
            report_fail($sformatf("result %0d inside_res %0b, expected %0b",
                                  n_results, out_ch.data.inside_res, due.inside_res));
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("no item moved for %0d cycles, %0d results outstanding",
               idle_cycles, pixel_due_q.size());
      $display("binary_image_rotation_top test failed");
      $finish;
    end
  end

  // result receiver with random stalls and one long hold-off
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (no_idle) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t due);
    read_tag_t tag;
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    if (it.cmd == CMD_READ) begin
      tag.typed = typed;
      tag.due = due;
      read_tag_q.push_back(tag);
    end else if (it.col < MAX_W && it.row < MAX_H) begin
      frame_sent[int'(it.row) * MAX_W + int'(it.col)] = 1'b1;
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // wait for every expected result, then let in-flight writes clear the pipe
  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    while (pixel_due_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 3) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    unique case (idx)
      CFG_COS:        cos_q = val[TRIG_W-1:0];
      CFG_SIN:        sin_q = val[TRIG_W-1:0];
      CFG_SRC_WIDTH:  src_w_q = val[SRC_W-1:0];
      CFG_SRC_HEIGHT: src_h_q = val[SRC_W-1:0];
      CFG_OUT_WIDTH:  out_w_q = val[OUT_W-1:0];
      CFG_OUT_HEIGHT: out_h_q = val[OUT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic plan_row_t pix_write(input int c, input int r, input int p);
    plan_row_t x;
    x.kind = ROW_ITEM;
    x.idx = CFG_COS;
    x.val = 0;
    x.it = '{cmd: CMD_WRITE, col: COORD_W'(c), row: COORD_W'(r), pixel_in: PIXEL_W'(p)};
    x.typed = 1'b0;
    x.due = '0;
    return x;
  endfunction

  function automatic plan_row_t pix_read(input int c, input int r, input bit typed,
                                         input int px, input bit ins);
    plan_row_t x;
    x.kind = ROW_ITEM;
    x.idx = CFG_COS;
    x.val = 0;
    x.it = '{cmd: CMD_READ, col: COORD_W'(c), row: COORD_W'(r), pixel_in: PIXEL_W'(8'h5A)};
    x.typed = typed;
    x.due = '{pixel_out: PIXEL_W'(px), inside_res: ins};
    return x;
  endfunction

  function automatic plan_row_t reg_set(input cfg_reg_t idx, input int v);
    plan_row_t x;
    x.kind = ROW_CFG;
    x.idx = idx;
    x.val = v;
    x.it = '0;
    x.typed = 1'b0;
    x.due = '0;
    return x;
  endfunction

  function automatic int pick_src_size();
    int r;
    r = $urandom_range(9);
    if (r < 6) return $urandom_range(16, 1);
    if (r < 8) return MAX_W;
    return $urandom_range(256, 1);
  endfunction

  function automatic int pick_out_size();
    int r;
    r = $urandom_range(9);
    if (r < 5) return $urandom_range(64, 1);
    if (r == 5) return 1;
    if (r < 8) return 512;
    return $urandom_range(512, 1);
  endfunction

  task automatic apply_settings(input int ph);
    int c, s, sw, sh, ow, oh;
    case (ph)
      0: begin
        c = -16384; s = -16384; sw = 1; sh = 1; ow = 1; oh = 1;
      end
      1: begin
        c = 16384; s = 16384; sw = 256; sh = 256; ow = 512; oh = 512;
      end
      2: begin
        c = 0; s = 16384; sw = 16; sh = 12; ow = 12; oh = 16;
      end
      default: begin
        case ($urandom_range(5))
          0: begin c = 16384;  s = 0; end
          1: begin c = -16384; s = 0; end
          2: begin c = 0; s = 16384; end
          3: begin c = 0; s = -16384; end
          default: begin
            c = int'($urandom_range(32768)) - 16384;
            s = int'($urandom_range(32768)) - 16384;
          end
        endcase
        sw = pick_src_size();
        sh = pick_src_size();
        ow = pick_out_size();
        oh = pick_out_size();
      end
    endcase
    drain_pipe();
    write_reg(CFG_COS, c);
    write_reg(CFG_SIN, s);
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_OUT_WIDTH, ow);
    write_reg(CFG_OUT_HEIGHT, oh);
  endtask

  // frame loads, noise writes outside the store and reads of the rotated frame
  task automatic run_phase(input int n);
    int k, r, addr, wlim, hlim;
    in_item_t it, fill;
    wlim = (src_w_q > MAX_W) ? MAX_W : int'(src_w_q);
    hlim = (src_h_q > MAX_H) ? MAX_H : int'(src_h_q);
    k = 0;
    while (k < n) begin
      r = $urandom_range(99);
      it.pixel_in = $urandom_range(1) ? PIXEL_W'($urandom_range(255)) : DARK;
      if (r < 30) begin
        it.cmd = CMD_WRITE;
        it.col = COORD_W'($urandom_range(wlim - 1));
        it.row = COORD_W'($urandom_range(hlim - 1));
      end else if (r < 36) begin
        it.cmd = CMD_WRITE;
        if ($urandom_range(1)) begin
          it.col = COORD_W'($urandom_range(511, MAX_W));
          it.row = COORD_W'($urandom_range(511));
        end else begin
          it.col = COORD_W'($urandom_range(511));
          it.row = COORD_W'($urandom_range(511, MAX_H));
        end
      end else begin
        it.cmd = CMD_READ;
        it.pixel_in = PIXEL_W'($urandom_range(255));
        it.col = ($urandom_range(99) < 70) ? COORD_W'($urandom_range(int'(out_w_q) - 1))
                                            : COORD_W'($urandom_range(511));
        it.row = ($urandom_range(99) < 70) ? COORD_W'($urandom_range(int'(out_h_q) - 1))
                                            : COORD_W'($urandom_range(511));
        // store the source pixel first if the read would land on an unwritten one
        if (map_point(it.col, it.row, addr) && !frame_sent[addr]) begin
          fill.cmd = CMD_WRITE;
          fill.col = COORD_W'(addr % MAX_W);
          fill.row = COORD_W'(addr / MAX_W);
          fill.pixel_in = $urandom_range(1) ? PIXEL_W'($urandom_range(255)) : DARK;
          send_item(fill, 1'b0, '0);
          k++;
        end
      end
      send_item(it, 1'b0, '0);
      k++;
    end
  endtask

  initial begin : main
    plan_row_t plan [$];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cos_q = COS_RESET;
    sin_q = SIN_RESET;
    src_w_q = SRC_SIZE_RESET;
    src_h_q = SRC_SIZE_RESET;
    out_w_q = OUT_SIZE_RESET;
    out_h_q = OUT_SIZE_RESET;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: identity rotation on a 256 x 256 frame
    plan.push_back(pix_write(0, 0, 0));
    plan.push_back(pix_write(255, 255, 255));
    plan.push_back(pix_write(128, 128, 1));
    plan.push_back(pix_write(1, 0, 8'h80));
    plan.push_back(pix_write(44, 5, 0));
    plan.push_back(pix_write(5, 44, 0));
    // writes beyond the store must not alias onto (44,5) or (5,44)
    plan.push_back(pix_write(300, 5, 255));
    plan.push_back(pix_write(5, 300, 255));
    plan.push_back(pix_read(128, 128, 1'b1, LIGHT, 1'b1));
    plan.push_back(pix_read(0, 0, 1'b1, DARK, 1'b1));
    plan.push_back(pix_read(255, 255, 1'b1, LIGHT, 1'b1));
    plan.push_back(pix_read(1, 0, 1'b1, LIGHT, 1'b1));
    plan.push_back(pix_read(44, 5, 1'b1, DARK, 1'b1));
    plan.push_back(pix_read(5, 44, 1'b1, DARK, 1'b1));
    plan.push_back(pix_read(256, 0, 1'b1, LIGHT, 1'b0));
    plan.push_back(pix_read(0, 256, 1'b1, LIGHT, 1'b0));
    plan.push_back(pix_read(511, 511, 1'b1, LIGHT, 1'b0));
    // zero source width: nothing is inside
    plan.push_back(reg_set(CFG_SRC_WIDTH, 0));
    plan.push_back(pix_read(128, 128, 1'b1, LIGHT, 1'b0));
    plan.push_back(pix_read(0, 0, 1'b1, LIGHT, 1'b0));
    // source size above the store: points past the store are outside
    plan.push_back(reg_set(CFG_SRC_WIDTH, 300));
    plan.push_back(reg_set(CFG_SRC_HEIGHT, 300));
    plan.push_back(pix_read(234, 106, 1'b1, LIGHT, 1'b0));
    plan.push_back(pix_read(106, 234, 1'b1, LIGHT, 1'b0));
    plan.push_back(pix_write(22, 22, 0));
    plan.push_back(pix_read(0, 0, 1'b1, DARK, 1'b1));
    // 45 degrees: negative product sums truncate toward zero
    plan.push_back(reg_set(CFG_SRC_WIDTH, 256));
    plan.push_back(reg_set(CFG_SRC_HEIGHT, 256));
    plan.push_back(reg_set(CFG_COS, 11585));
    plan.push_back(reg_set(CFG_SIN, 11585));
    plan.push_back(pix_read(128, 128, 1'b1, LIGHT, 1'b1));
    plan.push_back(pix_read(127, 128, 1'b0, 0, 1'b0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain_pipe();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_item(plan[i].it, plan[i].typed, plan[i].due);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      apply_settings(ph);
      if (ph == 3) hold_req = 1'b1;
      no_idle = (ph == 5);
      run_phase(PHASE_ITEMS);
    end
    no_idle = 1'b0;
    drain_pipe();

    $display("run: %0d items accepted, %0d reads, %0d results checked", n_items, n_reads,
             n_results);
    $display("run: %0d register settings incl. trig and size extremes, one long output hold",
             PHASES + 3);
    if (err_count == 0) begin
      $display("binary_image_rotation_top test passed");
    end else begin
      $display("%0d mismatches", err_count);
      $display("binary_image_rotation_top test failed");
    end
    $finish;
  end

endmodule
